### hw/rtl/oled_pkg.sv
// Shared types, constants and the 6x8 font ROM of the OLED text glyph streamer.
package oled_pkg;

    // Field widths
    localparam int CHAR_W         = 8;
    localparam int START_COLUMN_W = 7;
    localparam int COLUMN_W       = 8;
    localparam int PAGE_W         = 3;
    localparam int ADDR_W         = 7;
    localparam int BYTE_W         = 8;

    // Stream packing
    localparam int S_TDATA_W      = 24;
    localparam int S_CHAR_LSB     = 0;
    localparam int S_COLUMN_LSB   = S_CHAR_LSB + CHAR_W;
    localparam int S_PAGE_LSB     = S_COLUMN_LSB + START_COLUMN_W;
    localparam int M_TDATA_W      = 16;
    localparam int M_ADDR_LSB     = 0;
    localparam int M_PAYLOAD_LSB  = M_ADDR_LSB + ADDR_W;

    // Display geometry and font
    localparam int GLYPH_COLUMNS  = 6;
    localparam int PAGE_COUNT     = 8;
    localparam int GLYPH_COUNT    = 92;
    localparam int GLYPH_INDEX_W  = $clog2(GLYPH_COUNT);
    localparam logic [CHAR_W-1:0]   FIRST_GLYPH = 8'd32;
    localparam logic [CHAR_W-1:0]   LAST_GLYPH  = CHAR_W'(32 + GLYPH_COUNT - 1);
    localparam logic [COLUMN_W-1:0] WRAP_LIMIT  = 8'd126;

    // Byte sequence per character
    localparam int CMD_BYTES      = 3;
    localparam int BYTES_PER_CHAR = CMD_BYTES + GLYPH_COLUMNS;
    localparam int COUNT_W        = $clog2(BYTES_PER_CHAR);
    localparam int COL_IDX_W      = $clog2(GLYPH_COLUMNS);
    localparam logic [COUNT_W-1:0] BYTE_PAGE     = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] BYTE_COL_HIGH = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] BYTE_COL_LOW  = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] BYTE_FINAL    = COUNT_W'(BYTES_PER_CHAR - 1);

    // Controller command codes
    localparam logic [BYTE_W-1:0] CMD_PAGE_BASE   = 8'hB0;
    localparam logic [BYTE_W-1:0] CMD_COL_HIGH    = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_NIBBLE_MASK = 8'h0F;

    localparam logic [ADDR_W-1:0] DEVICE_ADDRESS_RESET = 7'd60;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PAGE_W-1:0]         page;
        logic [START_COLUMN_W-1:0] column;
        logic                      glyph_valid;
        logic [GLYPH_INDEX_W-1:0]  glyph_index;
    } oled_desc_t;

    // Column 0 sits in the top byte, matching the reading order of the table
    typedef logic [GLYPH_COLUMNS-1:0][BYTE_W-1:0] glyph_row_t;

    function automatic glyph_row_t font_row(input logic [GLYPH_INDEX_W-1:0] idx);
        unique case (idx)
            7'd0:  font_row = 48'h000000000000;
            7'd1:  font_row = 48'h0000002f0000;
            7'd2:  font_row = 48'h000007000700;
            7'd3:  font_row = 48'h00147f147f14;
            7'd4:  font_row = 48'h00242a7f2a12;
            7'd5:  font_row = 48'h006264081323;
            7'd6:  font_row = 48'h003649552250;
            7'd7:  font_row = 48'h000005030000;
            7'd8:  font_row = 48'h00001c224100;
            7'd9:  font_row = 48'h000041221c00;
            7'd10: font_row = 48'h0014083e0814;
            7'd11: font_row = 48'h0008083e0808;
            7'd12: font_row = 48'h000000a06000;
            7'd13: font_row = 48'h000808080808;
            7'd14: font_row = 48'h000060600000;
            7'd15: font_row = 48'h002010080402;
            7'd16: font_row = 48'h003e5149453e;
            7'd17: font_row = 48'h0000427f4000;
            7'd18: font_row = 48'h004261514946;
            7'd19: font_row = 48'h002141454b31;
            7'd20: font_row = 48'h001814127f10;
            7'd21: font_row = 48'h002745454539;
            7'd22: font_row = 48'h003c4a494930;
            7'd23: font_row = 48'h000171090503;
            7'd24: font_row = 48'h003649494936;
            7'd25: font_row = 48'h00064949291e;
            7'd26: font_row = 48'h000036360000;
            7'd27: font_row = 48'h000056360000;
            7'd28: font_row = 48'h000814224100;
            7'd29: font_row = 48'h001414141414;
            7'd30: font_row = 48'h000041221408;
            7'd31: font_row = 48'h000201510906;
            7'd32: font_row = 48'h00324959513e;
            7'd33: font_row = 48'h007c1211127c;
            7'd34: font_row = 48'h007f49494936;
            7'd35: font_row = 48'h003e41414122;
            7'd36: font_row = 48'h007f4141221c;
            7'd37: font_row = 48'h007f49494941;
            7'd38: font_row = 48'h007f09090901;
            7'd39: font_row = 48'h003e4149497a;
            7'd40: font_row = 48'h007f0808087f;
            7'd41: font_row = 48'h0000417f4100;
            7'd42: font_row = 48'h002040413f01;
            7'd43: font_row = 48'h007f08142241;
            7'd44: font_row = 48'h007f40404040;
            7'd45: font_row = 48'h007f020c027f;
            7'd46: font_row = 48'h007f0408107f;
            7'd47: font_row = 48'h003e4141413e;
            7'd48: font_row = 48'h007f09090906;
            7'd49: font_row = 48'h003e4151215e;
            7'd50: font_row = 48'h007f09192946;
            7'd51: font_row = 48'h004649494931;
            7'd52: font_row = 48'h0001017f0101;
            7'd53: font_row = 48'h003f4040403f;
            7'd54: font_row = 48'h001f2040201f;
            7'd55: font_row = 48'h003f4038403f;
            7'd56: font_row = 48'h006314081463;
            7'd57: font_row = 48'h000708700807;
            7'd58: font_row = 48'h006151494543;
            7'd59: font_row = 48'h00007f414100;
            7'd60: font_row = 48'h00552a552a55;
            7'd61: font_row = 48'h000041417f00;
            7'd62: font_row = 48'h000402010204;
            7'd63: font_row = 48'h004040404040;
            7'd64: font_row = 48'h000001020400;
            7'd65: font_row = 48'h002054545478;
            7'd66: font_row = 48'h007f48444438;
            7'd67: font_row = 48'h003844444420;
            7'd68: font_row = 48'h00384444487f;
            7'd69: font_row = 48'h003854545418;
            7'd70: font_row = 48'h00087e090102;
            7'd71: font_row = 48'h0018a4a4a47c;
            7'd72: font_row = 48'h007f08040478;
            7'd73: font_row = 48'h0000447d4000;
            7'd74: font_row = 48'h004080847d00;
            7'd75: font_row = 48'h007f10284400;
            7'd76: font_row = 48'h0000417f4000;
            7'd77: font_row = 48'h007c04180478;
            7'd78: font_row = 48'h007c08040478;
            7'd79: font_row = 48'h003844444438;
            7'd80: font_row = 48'h00fc24242418;
            7'd81: font_row = 48'h0018242418fc;
            7'd82: font_row = 48'h007c08040408;
            7'd83: font_row = 48'h004854545420;
            7'd84: font_row = 48'h00043f444020;
            7'd85: font_row = 48'h003c4040207c;
            7'd86: font_row = 48'h001c2040201c;
            7'd87: font_row = 48'h003c4030403c;
            7'd88: font_row = 48'h004428102844;
            7'd89: font_row = 48'h001ca0a0a07c;
            7'd90: font_row = 48'h004464544c44;
            7'd91: font_row = 48'h141414141414;
            default: font_row = '0;
        endcase
    endfunction

endpackage

### hw/rtl/oled_text_glyph_streamer_top.sv
// Top level of the OLED text glyph streamer: front end, queue, back end, address register.
// Usage
//   Input stream (s_*): one transaction per character. s_tdata carries the
//   ASCII code, the start column and start page; s_tuser set means "start of
//   string", so the cursor is loaded from those start fields first.
//   Output stream (m_*): nine transactions per character, in order: page
//   command, high column nibble command, low column nibble command, then six
//   glyph column data bytes. m_tuser marks a data byte, m_tlast the ninth
//   byte, and m_tdata holds the bus address next to the byte itself.
//   cfg_wr_en/cfg_wr_data load the 7-bit controller address; write it only
//   while the block is idle.
//   When the back end is idle, a character's first byte passes the descriptor
//   queue, the back end's descriptor registers and the output register to m_*.
//   The back end's byte counter puts one byte per cycle into the output
//   register while m_tready does not stall it. The two-entry descriptor queue
//   lets the front end take further characters meanwhile.
//   Reset (aresetn low, synchronous): cursor to column 0 page 0, queue and
//   output emptied, address back to 60.
//   Receiver stall: m_* holds its transaction; the back end pauses, the queue
//   fills, and s_tready drops once it is full.
module oled_text_glyph_streamer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [oled_pkg::ADDR_W-1:0]    cfg_wr_data,
    // characters in
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] character, [14:8] start_column, [17:15] start_page, [23:18] zero
    input  logic [oled_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] start_of_string
    input  logic                           s_tuser,
    // bus bytes out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [6:0] bus_address, [14:7] payload, [15] zero
    output logic [oled_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] is_data
    output logic                           m_tuser,
    // last_byte
    output logic                           m_tlast
);
    import oled_pkg::*;

    logic [ADDR_W-1:0] device_address_reg;

    logic              q_full;
    logic              q_wr_en;
    oled_desc_t        q_wr_desc;
    logic              q_rd_en;
    logic              q_rd_valid;
    oled_desc_t        q_rd_desc;

    // controller address, tagged on every outgoing byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= DEVICE_ADDRESS_RESET;
        end else if (cfg_wr_en) begin
            device_address_reg <= cfg_wr_data;
        end
    end

    // cursor tracking and glyph classification
    oled_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_wr_en   (q_wr_en),
        .q_wr_desc (q_wr_desc)
    );

    // decouples acceptance from byte output
    oled_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr_en),
        .wr_desc  (q_wr_desc),
        .full     (q_full),
        .rd_en    (q_rd_en),
        .rd_valid (q_rd_valid),
        .rd_desc  (q_rd_desc)
    );

    // command and glyph byte sequencer
    oled_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_rd_valid),
        .q_rd_en        (q_rd_en),
        .q_desc         (q_rd_desc),
        .device_address (device_address_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

endmodule

### hw/rtl/oled_front.sv
// Front end: accepts characters, keeps the cursor and queues a render descriptor.
module oled_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] character, [14:8] start_column, [17:15] start_page, rest zero
    input  logic [oled_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] start_of_string
    input  logic                          s_tuser,
    input  logic                          q_full,
    output logic                          q_wr_en,
    output oled_pkg::oled_desc_t          q_wr_desc
);
    import oled_pkg::*;

    logic [COLUMN_W-1:0]       cursor_column_reg, cursor_column_next;
    logic [PAGE_W-1:0]         cursor_page_reg, cursor_page_next;
    logic [CHAR_W-1:0]         in_char;
    logic [START_COLUMN_W-1:0] in_column;
    logic [PAGE_W-1:0]         in_page;
    logic [COLUMN_W-1:0]       base_column;
    logic [PAGE_W-1:0]         base_page;
    logic [COLUMN_W-1:0]       draw_column;
    logic [PAGE_W-1:0]         draw_page;

    assign in_char   = s_tdata[S_CHAR_LSB +: CHAR_W];
    assign in_column = s_tdata[S_COLUMN_LSB +: START_COLUMN_W];
    assign in_page   = s_tdata[S_PAGE_LSB +: PAGE_W];

    assign s_tready = !q_full;
    assign q_wr_en  = s_tvalid && s_tready;

    always_comb begin
        if (s_tuser) begin
            base_column = {1'b0, in_column};
            base_page   = PAGE_W'(32'(in_page) % PAGE_COUNT);
        end else begin
            base_column = cursor_column_reg;
            base_page   = cursor_page_reg;
        end

        // past the right edge: restart at column 0 of the next page
        if (base_column > WRAP_LIMIT) begin
            draw_column = '0;
            draw_page   = (base_page == PAGE_W'(PAGE_COUNT - 1)) ? '0 : base_page + 1'b1;
        end else begin
            draw_column = base_column;
            draw_page   = base_page;
        end

        q_wr_desc.page        = draw_page;
        q_wr_desc.column      = draw_column[START_COLUMN_W-1:0];
        q_wr_desc.glyph_valid = (in_char >= FIRST_GLYPH) && (in_char <= LAST_GLYPH);
        q_wr_desc.glyph_index = GLYPH_INDEX_W'(in_char - FIRST_GLYPH);

        cursor_column_next = draw_column + COLUMN_W'(GLYPH_COLUMNS);
        cursor_page_next   = draw_page;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_column_reg <= '0;
            cursor_page_reg   <= '0;
        end else if (q_wr_en) begin
            cursor_column_reg <= cursor_column_next;
            cursor_page_reg   <= cursor_page_next;
        end
    end

endmodule

### hw/rtl/oled_queue.sv
// Short descriptor queue between the front and back ends.
module oled_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  oled_pkg::oled_desc_t wr_desc,
    output logic                 full,
    input  logic                 rd_en,
    output logic                 rd_valid,
    output oled_pkg::oled_desc_t rd_desc
);
    import oled_pkg::*;

    oled_desc_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_desc  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 1'b1;
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/oled_back.sv
// Back end: expands one descriptor into nine bus bytes through an output register.
module oled_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_rd_en,
    input  oled_pkg::oled_desc_t           q_desc,
    input  logic [oled_pkg::ADDR_W-1:0]    device_address,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [6:0] bus_address, [14:7] payload, [15] zero
    output logic [oled_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] is_data
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import oled_pkg::*;

    logic                      busy_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [PAGE_W-1:0]         page_reg;
    logic [START_COLUMN_W-1:0] column_reg;
    glyph_row_t                row_reg;

    logic                      m_tvalid_reg;
    logic [ADDR_W-1:0]         m_addr_reg;
    logic [BYTE_W-1:0]         m_payload_reg;
    logic                      m_is_data_reg;
    logic                      m_last_reg;

    logic                      out_free;
    logic                      emit;
    logic                      finishing;
    logic [COL_IDX_W-1:0]      col_idx;
    logic [COL_IDX_W-1:0]      rev_idx;
    logic [BYTE_W-1:0]         byte_value;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = busy_reg && out_free;
    assign finishing = emit && (count_reg == BYTE_FINAL);
    // next descriptor is taken when idle, or as the last byte of the current one leaves
    assign q_rd_en   = q_valid && (!busy_reg || finishing);

    always_comb begin
        col_idx    = '0;
        rev_idx    = '0;
        byte_value = '0;
        priority if (count_reg == BYTE_PAGE) begin
            byte_value = CMD_PAGE_BASE + BYTE_W'(page_reg);
        end else if (count_reg == BYTE_COL_HIGH) begin
            byte_value = CMD_COL_HIGH | BYTE_W'(column_reg[START_COLUMN_W-1:4]);
        end else if (count_reg == BYTE_COL_LOW) begin
            byte_value = BYTE_W'(column_reg) & CMD_NIBBLE_MASK;
        end else begin
            col_idx    = COL_IDX_W'(count_reg - COUNT_W'(CMD_BYTES));
            rev_idx    = COL_IDX_W'(GLYPH_COLUMNS - 1) - col_idx;
            byte_value = row_reg[rev_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            if (q_rd_en) begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end else if (finishing) begin
                busy_reg  <= 1'b0;
            end else if (emit) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_rd_en) begin
            page_reg   <= q_desc.page;
            column_reg <= q_desc.column;
            row_reg    <= q_desc.glyph_valid ? font_row(q_desc.glyph_index) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_addr_reg    <= device_address;
            m_payload_reg <= byte_value;
            m_is_data_reg <= (count_reg >= COUNT_W'(CMD_BYTES));
            m_last_reg    <= (count_reg == BYTE_FINAL);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_payload_reg, m_addr_reg};
    assign m_tuser  = m_is_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

### hw/rtl/oled_checker.sv
// Port-level assertions for the OLED text glyph streamer, bound to the top level.
module oled_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [oled_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);
    import oled_pkg::*;

    // output register empties on reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid not cleared after reset");

    // a stalled transaction keeps its contents
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    // the closing byte of a character is always glyph data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("last byte flagged as command");

    // command bytes are page select or one of the two column nibble commands
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            (m_tdata[M_PAYLOAD_LSB+4 +: 4] == 4'hB) ||
            (m_tdata[M_PAYLOAD_LSB+4 +: 4] == 4'h1) ||
            (m_tdata[M_PAYLOAD_LSB+4 +: 4] == 4'h0))
        else $error("malformed command byte");

endmodule

bind oled_text_glyph_streamer_top oled_checker u_oled_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
